### sv/tpgw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the thermal pixel gray window block.
// Used by tpgw_div_stage and thermal_pixel_gray_window; no dependencies.
package tpgw_pkg;

	localparam int unsigned RAW_W  = 17;
	localparam int unsigned MAG_W  = 16;
	localparam int unsigned DK_W   = 13;
	localparam int unsigned GRAY_W = 8;
	// 254 * 8191 fits in 21 bits
	localparam int unsigned NUM_W  = 21;

	// x / 10 == (x * 52429) >> 19 for every 16-bit x
	localparam logic [MAG_W-1:0] DIV10_MUL   = 16'd52429;
	localparam int unsigned      DIV10_SHIFT = 19;
	localparam int unsigned      PROD_W      = 2 * MAG_W;

	localparam logic [GRAY_W-1:0] GRAY_ZERO = 8'd0;
	localparam logic [GRAY_W-1:0] GRAY_MIN  = 8'd1;
	localparam logic [GRAY_W-1:0] GRAY_MAX  = 8'd255;

	localparam int unsigned BITS_PER_DIV_STAGE = 2;
	localparam int unsigned DIV_STAGES         = GRAY_W / BITS_PER_DIV_STAGE;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 2'd1;

	localparam logic [DK_W-1:0] LOW_RESET  = 13'd3031;
	localparam logic [DK_W-1:0] HIGH_RESET = 13'd3131;

	// Payload carried through the divider stages
	typedef struct packed {
		logic              special;
		logic [GRAY_W-1:0] sgray;
		logic [NUM_W-1:0]  rem;
		logic [DK_W-1:0]   den;
		logic [GRAY_W-1:0] quo;
		logic [DK_W-1:0]   dk;
		logic              fe;
	} div_t;

endpackage

### sv/tpgw_div_stage.sv
`timescale 1ns / 1ps
// One pipeline stage of the ramp divider: two restoring quotient bits.
// Depends on tpgw_pkg for div_t and widths.
module tpgw_div_stage import tpgw_pkg::*; #(
	parameter int unsigned QBIT = 7
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  div_t in_data,
	output logic in_ready,
	output logic out_valid,
	output div_t out_data,
	input  logic out_ready
);

	localparam int unsigned QHI = QBIT;
	localparam int unsigned QLO = QBIT - 1;

	logic             valid_q;
	div_t             data_q;
	div_t             nxt;
	logic [NUM_W:0]   d_hi, d_lo, r_in, r_mid, r_out;
	logic             q_hi, q_lo;

	always_comb begin
		r_in  = {1'b0, in_data.rem};
		d_hi  = (NUM_W+1)'(in_data.den) << QHI;
		q_hi  = r_in >= d_hi;
		r_mid = q_hi ? r_in - d_hi : r_in;
		d_lo  = (NUM_W+1)'(in_data.den) << QLO;
		q_lo  = r_mid >= d_lo;
		r_out = q_lo ? r_mid - d_lo : r_mid;
		nxt = in_data;
		nxt.rem = r_out[NUM_W-1:0];
		nxt.quo[QHI] = q_hi;
		nxt.quo[QLO] = q_lo;
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

endmodule

### sv/thermal_pixel_gray_window.sv
`timescale 1ns / 1ps
// Thermal pixel window/level gray mapping, top level.
// Depends on tpgw_pkg and tpgw_div_stage.
//
// Takes one pixel per clock unless pix_stall is high: a signed centiKelvin raw value
// is clamped at zero and divided by ten (reciprocal multiply) to deciKelvin, then
// mapped to an 8-bit gray through the window [low_decikelvin, high_decikelvin]: zero
// gives 0, above the window 255, below it or with high equal to low 1, inside it
// 1 + floor(254*(v-low)/(high-low)). Throughput is one pixel per clock unless stalled.
// Registered steps: the multiply, the window compare, then the divider stages, each
// resolving two quotient bits. Each stage holds its own item under stall, so bubbles
// close up and input keeps flowing into empty stages while a result waits. Write the
// window registers only while idle; the configuration port is always ready.
module thermal_pixel_gray_window import tpgw_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pix_valid,
	output logic                    pix_stall,
	input  logic signed [RAW_W-1:0] raw_value,
	input  logic                    frame_end,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic [GRAY_W-1:0]       gray_level,
	output logic [DK_W-1:0]         decikelvin,
	output logic                    frame_end_out,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [DK_W-1:0]         cfg_data
);

	logic [DK_W-1:0] low_q, high_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_RESET;
			high_q <= HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOW:  low_q  <= cfg_data;
				CFG_HIGH: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: clamp and reciprocal multiply
	logic              valid_s1, ready_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              fe_s1;
	logic [MAG_W-1:0]  mag;

	// Stage 2: window compare and ramp numerator
	logic              valid_s2, ready_s2;
	div_t              data_s2;
	div_t              nxt_s2;
	logic [DK_W-1:0]   v;
	logic [DK_W-1:0]   dlt;

	div_t              stg_data  [DIV_STAGES+1];
	logic              stg_valid [DIV_STAGES+1];
	logic              stg_ready [DIV_STAGES+1];

	assign mag = raw_value[RAW_W-1] ? '0 : raw_value[MAG_W-1:0];

	assign ready_s1  = !valid_s1 || ready_s2;
	assign pix_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && pix_valid) begin
			prod_s1 <= PROD_W'(mag) * PROD_W'(DIV10_MUL);
			fe_s1   <= frame_end;
		end
	end

	always_comb begin
		v   = prod_s1[DIV10_SHIFT +: DK_W];
		dlt = v - low_q;
		nxt_s2.dk      = v;
		nxt_s2.fe      = fe_s1;
		nxt_s2.quo     = '0;
		nxt_s2.den     = high_q - low_q;
		// 254*d as 256*d - 2*d
		nxt_s2.rem     = {dlt, 8'b0} - NUM_W'({dlt, 1'b0});
		nxt_s2.special = 1'b1;
		priority if (v == '0) begin
			nxt_s2.sgray = GRAY_ZERO;
		end else if (v > high_q) begin
			nxt_s2.sgray = GRAY_MAX;
		end else if (v < low_q || high_q == low_q) begin
			nxt_s2.sgray = GRAY_MIN;
		end else begin
			nxt_s2.sgray   = GRAY_MIN;
			nxt_s2.special = 1'b0;
		end
	end

	assign ready_s2 = !valid_s2 || stg_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			data_s2 <= nxt_s2;
		end
	end

	assign stg_valid[0] = valid_s2;
	assign stg_data[0]  = data_s2;
	assign stg_ready[DIV_STAGES] = !res_stall;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		tpgw_div_stage #(
			.QBIT(GRAY_W - 1 - g * BITS_PER_DIV_STAGE)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (stg_valid[g]),
			.in_data  (stg_data[g]),
			.in_ready (stg_ready[g]),
			.out_valid(stg_valid[g+1]),
			.out_data (stg_data[g+1]),
			.out_ready(stg_ready[g+1])
		);
	end

	assign res_valid     = stg_valid[DIV_STAGES];
	assign decikelvin    = stg_data[DIV_STAGES].dk;
	assign frame_end_out = stg_data[DIV_STAGES].fe;
	assign gray_level    = stg_data[DIV_STAGES].special ? stg_data[DIV_STAGES].sgray
	                                                    : stg_data[DIV_STAGES].quo + GRAY_MIN;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for thermal_pixel_gray_window: random pixels, window settings and
// handshake gaps, each result checked against a gray window predictor in a scoreboard class.
// Depends on tpgw_pkg and the thermal_pixel_gray_window RTL.
module tb;
	import tpgw_pkg::*;

	localparam int unsigned RAMP_SPAN   = 254;
	localparam int          RAW_DIVISOR = 10;
	localparam int          DK_TOP      = 6553;
	localparam int          RAW_TOP     = 65535;
	localparam int          REG_TOP     = 8191;
	localparam int          HOLD_CYCLES = 100;
	localparam int          PHASES      = 12;
	localparam int          PHASE_ITEMS = 75;
	localparam int          DRAIN_WAIT  = 10;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          PRINT_CAP   = 40;

	// Indexes with no register behind them; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef struct {
		logic [GRAY_W-1:0] gray;
		logic [DK_W-1:0]   dk;
		logic              fe;
	} pixel_out_t;

	class gray_scoreboard;
		logic [DK_W-1:0] win_low;
		logic [DK_W-1:0] win_high;
		pixel_out_t      pending_pixels[$];
		int              mismatches;

		function new();
			win_low = LOW_RESET;
			win_high = HIGH_RESET;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DK_W-1:0] data);
			case (idx)
				CFG_LOW: win_low = data;
				CFG_HIGH: win_high = data;
				default: ;
			endcase
		endfunction

		function logic [GRAY_W-1:0] window_gray(logic [DK_W-1:0] v);
			int unsigned ramp;
			if (v == 0)
				return GRAY_ZERO;
			if (v > win_high)
				return GRAY_MAX;
			if (v < win_low)
				return GRAY_MIN;
			if (win_high == win_low)
				return GRAY_MIN;
			ramp = 1 + RAMP_SPAN * (v - win_low) / (win_high - win_low);
			if (ramp > GRAY_MAX)
				ramp = GRAY_MAX;
			return GRAY_W'(ramp);
		endfunction

		function void note_pixel(logic signed [RAW_W-1:0] raw, logic fe);
			pixel_out_t e;
			if (raw < 0)
				e.dk = '0;
			else
				e.dk = DK_W'(int'(raw) / RAW_DIVISOR);
			e.gray = window_gray(e.dk);
			e.fe = fe;
			pending_pixels.push_back(e);
		endfunction

		task report_mismatch(string what, int got, int want);
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
		endtask

		task check_pixel(logic [GRAY_W-1:0] gray, logic [DK_W-1:0] dk, logic fe);
			pixel_out_t e;
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected result, gray", gray, -1);
				return;
			end
			e = pending_pixels.pop_front();
			if (gray !== e.gray)
				report_mismatch("gray_level", gray, e.gray);
			if (dk !== e.dk)
				report_mismatch("decikelvin", dk, e.dk);
			if (fe !== e.fe)
				report_mismatch("frame_end_out", fe, e.fe);
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    pix_valid = 1'b0;
	logic                    pix_stall;
	logic signed [RAW_W-1:0] raw_value = '0;
	logic                    frame_end = 1'b0;
	logic                    res_valid;
	logic                    res_stall = 1'b0;
	logic [GRAY_W-1:0]       gray_level;
	logic [DK_W-1:0]         decikelvin;
	logic                    frame_end_out;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [DK_W-1:0]         cfg_data = '0;

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit hold_request = 1'b0;
	int cycles = 0;

	gray_scoreboard sb = new();

	thermal_pixel_gray_window dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.raw_value(raw_value),
		.frame_end(frame_end),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.gray_level(gray_level),
		.decikelvin(decikelvin),
		.frame_end_out(frame_end_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_pixel(gray_level, decikelvin, frame_end_out);
	end

	// Mostly short gaps, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				stall_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
				if (rx_idle_on && $urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	task automatic send_pixel(int raw, logic fe);
		int gap;
		pix_valid <= 1'b1;
		raw_value <= RAW_W'(raw);
		frame_end <= fe;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
		sb.note_pixel(RAW_W'(raw), fe);
		gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Leaves cfg_valid high; the caller drops it after its last write
	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= DK_W'(data);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, DK_W'(data));
	endtask

	task automatic program_window(int lo, int hi);
		if ($urandom_range(0, 1)) begin
			set_reg(CFG_LOW, lo);
			set_reg(CFG_HIGH, hi);
		end else begin
			set_reg(CFG_HIGH, hi);
			set_reg(CFG_LOW, lo);
		end
		cfg_valid <= 1'b0;
	endtask

	// Drop valid first so the last pixel is not offered again
	task automatic wait_drain();
		pix_valid <= 1'b0;
		while (sb.pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic pick_window(output int lo, output int hi);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			lo = $urandom_range(1, DK_TOP);
			hi = lo + $urandom_range(1, 600);
			if (hi > REG_TOP)
				hi = REG_TOP;
		end else if (sel < 70) begin
			lo = $urandom_range(0, DK_TOP);
			hi = lo;
		end else if (sel < 85) begin
			lo = $urandom_range(0, REG_TOP);
			hi = $urandom_range(0, REG_TOP);
		end else if (sel < 90) begin
			lo = 0;
			hi = REG_TOP;
		end else if (sel < 95) begin
			lo = 0;
			hi = $urandom_range(1, 50);
		end else begin
			hi = $urandom_range(0, 3000);
			lo = hi + $urandom_range(1, 3000);
		end
	endtask

	// Bias toward the window and its edges; keep some noise and negatives
	function automatic int pick_raw(int lo, int hi);
		int sel;
		int dk;
		int raw;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			if (sel < 45)
				dk = (lo > DK_TOP) ? $urandom_range(0, DK_TOP)
					: $urandom_range(lo, (hi > DK_TOP) ? DK_TOP : hi);
			else
				dk = ($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 4) - 2;
			if (dk < 0)
				dk = 0;
			if (dk > DK_TOP)
				dk = DK_TOP;
			raw = dk * RAW_DIVISOR + $urandom_range(0, RAW_DIVISOR - 1);
			if (raw > RAW_TOP)
				raw = RAW_TOP;
		end else if (sel < 75)
			raw = $urandom_range(0, 2 * RAW_TOP + 1) - (RAW_TOP + 1);
		else if (sel < 85)
			raw = -$urandom_range(1, RAW_TOP + 1);
		else if (sel < 90)
			raw = $urandom_range(0, 2 * RAW_DIVISOR - 1);
		else
			raw = $urandom_range(0, RAW_TOP);
		return raw;
	endfunction

	initial begin
		int lo;
		int hi;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset window 3031..3131: zero, negatives, extremes, bounds, mid-ramp
		send_pixel(0, 1'b1);
		send_pixel(-1, 1'b0);
		send_pixel(-65536, 1'b0);
		send_pixel(9, 1'b0);
		send_pixel(10, 1'b0);
		send_pixel(30309, 1'b0);
		send_pixel(30310, 1'b1);
		send_pixel(30319, 1'b0);
		send_pixel(30810, 1'b0);
		send_pixel(31310, 1'b0);
		send_pixel(31319, 1'b0);
		send_pixel(31320, 1'b0);
		send_pixel(RAW_TOP, 1'b1);
		wait_drain();
		// Widest window: zero stays zero even with low at 0
		program_window(0, REG_TOP);
		send_pixel(10, 1'b0);
		send_pixel(RAW_TOP, 1'b0);
		send_pixel(0, 1'b1);
		wait_drain();
		// Empty window
		program_window(5000, 5000);
		send_pixel(49990, 1'b0);
		send_pixel(50000, 1'b0);
		send_pixel(50010, 1'b1);
		wait_drain();
		// Inverted window never reaches the ramp
		program_window(6000, 1000);
		send_pixel(5000, 1'b0);
		send_pixel(30000, 1'b0);
		send_pixel(RAW_TOP, 1'b1);
		wait_drain();
		set_reg(CFG_SPARE_A, 0);
		set_reg(CFG_SPARE_B, REG_TOP);
		cfg_valid <= 1'b0;
		send_pixel(30000, 1'b0);
		wait_drain();
		program_window(0, 0);
		send_pixel(10, 1'b1);

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drain();
			pick_window(lo, hi);
			if (phase == PHASES - 1) begin
				lo = REG_TOP;
				hi = REG_TOP;
			end
			program_window(lo, hi);
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			if (phase == 1) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			// Long hold-off while pixels keep coming: fill the pipe
			if (phase == 4) begin
				tx_idle_on = 1'b0;
				hold_request = 1'b1;
			end
			repeat (PHASE_ITEMS)
				send_pixel(pick_raw(lo, hi), $urandom_range(0, 7) == 0);
		end
		pix_valid <= 1'b0;

		wait_drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
